@@ sv/ralt_pkg.sv @@
`timescale 1ns / 1ps
// Package for the room access list toggle block.
// Holds field widths, status codes, parameter defaults and the result struct.
package ralt_pkg;

  localparam int ROOM_W   = 14;
  localparam int CARD_W   = 32;
  localparam int STATUS_W = 3;

  localparam int ROOMS_DEF          = 4;
  localparam int SLOTS_PER_ROOM_DEF = 8;
  localparam int ID_BITS_DEF        = 32;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ROOM_W-1:0]   room_t;

  localparam room_t FIRST_ROOM_RESET = 14'd300;

  localparam status_t ST_INVALID = 3'd0;
  localparam status_t ST_ABSENT  = 3'd1;
  localparam status_t ST_PRESENT = 3'd2;
  localparam status_t ST_REMOVED = 3'd3;
  localparam status_t ST_ADDED   = 3'd4;
  localparam status_t ST_FULL    = 3'd5;

  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  typedef struct packed {
    logic    valid;
    status_t status;
  } res_t;

endpackage

@@ sv/ralt_in_if.sv @@
`timescale 1ns / 1ps
// Input channel interface: valid/ready plus operation, room number and card ID.
// Depends on ralt_pkg.
interface ralt_in_if;
  import ralt_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic [ROOM_W-1:0]   room_number;
  logic [CARD_W-1:0]   card_id;

  modport source (output valid, output operation, output room_number, output card_id,
                  input ready);
  modport sink   (input valid, input operation, input room_number, input card_id,
                  output ready);
endinterface

@@ sv/ralt_out_if.sv @@
`timescale 1ns / 1ps
// Result channel interface: valid/ready plus the status code.
// Depends on ralt_pkg.
interface ralt_out_if;
  import ralt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

@@ sv/ralt_id_mem.sv @@
`timescale 1ns / 1ps
// Card ID store: single write port, single read port with a registered read output.
// No dependencies.
module ralt_id_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ralt_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: clears the store after reset, then per item in a valid room walks
// its slots, records the first match and first empty slot, and writes back on
// a toggle unless the room is full. Depends on ralt_pkg and ralt_in_if.
module ralt_ctrl #(
  parameter int ROOMS          = 4,
  parameter int SLOTS_PER_ROOM = 8,
  parameter int ID_BITS        = 32,
  parameter int AW             = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ralt_in_if.sink              in_ch,
  input  ralt_pkg::room_t      first_room,
  output ralt_pkg::res_t       res,
  input  logic                 res_ready,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [ID_BITS-1:0]   mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  logic [ID_BITS-1:0]   mem_rdata
);
  import ralt_pkg::*;

  localparam int DEPTH = ROOMS * SLOTS_PER_ROOM;
  localparam int RIW   = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int SCW   = (SLOTS_PER_ROOM > 1) ? $clog2(SLOTS_PER_ROOM) : 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [SCW-1:0]     slot_r, slot_nxt;
  logic               hit_r, hit_nxt;
  logic               emp_r, emp_nxt;
  logic [AW-1:0]      hit_addr_r, hit_addr_nxt;
  logic [AW-1:0]      emp_addr_r, emp_addr_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;
  logic               op_r, op_nxt;
  status_t            status_r, status_nxt;

  logic               in_fire;
  logic               below_base;
  room_t              room_diff;
  logic               room_bad;
  logic [RIW-1:0]     room_idx;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign below_base  = in_ch.room_number < first_room;
  assign room_diff   = in_ch.room_number - first_room;
  assign room_bad    = below_base || (room_diff >= ROOM_W'(ROOMS));
  assign room_idx    = room_diff[RIW-1:0];

  assign mem_raddr  = addr_r;
  assign res.valid  = (state_r == S_RESP);
  assign res.status = status_r;

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    slot_nxt     = slot_r;
    hit_nxt      = hit_r;
    emp_nxt      = emp_r;
    hit_addr_nxt = hit_addr_r;
    emp_addr_nxt = emp_addr_r;
    key_nxt      = key_r;
    op_nxt       = op_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          key_nxt  = ID_BITS'(in_ch.card_id);
          op_nxt   = in_ch.operation;
          hit_nxt  = 1'b0;
          emp_nxt  = 1'b0;
          slot_nxt = '0;
          addr_nxt = AW'(room_idx * SLOTS_PER_ROOM);
          if (room_bad) begin
            status_nxt = ST_INVALID;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!hit_r && (mem_rdata == key_r)) begin
          hit_nxt      = 1'b1;
          hit_addr_nxt = addr_r;
        end
        if (!emp_r && (mem_rdata == '0)) begin
          emp_nxt      = 1'b1;
          emp_addr_nxt = addr_r;
        end
        if (slot_r == SCW'(SLOTS_PER_ROOM - 1)) begin
          state_nxt = S_DECIDE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
        if (op_r == OP_CHECK) begin
          status_nxt = hit_r ? ST_PRESENT : ST_ABSENT;
        end else if (hit_r) begin
          mem_we     = 1'b1;
          mem_waddr  = hit_addr_r;
          mem_wdata  = '0;
          status_nxt = ST_REMOVED;
        end else if (emp_r) begin
          mem_we     = 1'b1;
          mem_waddr  = emp_addr_r;
          mem_wdata  = key_r;
          status_nxt = ST_ADDED;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      slot_r  <= '0;
      hit_r   <= 1'b0;
      emp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      slot_r  <= slot_nxt;
      hit_r   <= hit_nxt;
      emp_r   <= emp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_addr_r <= hit_addr_nxt;
    emp_addr_r <= emp_addr_nxt;
    key_r      <= key_nxt;
    op_r       <= op_nxt;
    status_r   <= status_nxt;
  end

  // Store is only written while clearing or when a toggle is resolved.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_DECIDE))
    else $error("store written outside clear or decide");

  // Every compare consumes data from a read issued the cycle before.
  a_read_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_READ))
    else $error("compare without preceding read");

  // A valid room always starts a slot walk at the room's first slot.
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !room_bad) |=> (state_r == S_READ && slot_r == '0))
    else $error("slot walk did not start");

  // A toggle that hit clears the matching slot.
  a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && op_r == OP_TOGGLE && hit_r) |->
      (mem_we && mem_wdata == '0 && mem_waddr == hit_addr_r))
    else $error("remove did not clear the slot");

endmodule

@@ sv/room_access_list_toggle.sv @@
`timescale 1ns / 1ps
// Top level of the room access list toggle block.
// Depends on ralt_pkg, ralt_in_if, ralt_out_if, ralt_id_mem and ralt_ctrl.
//
// Per-room access list of card IDs held in one synchronous RAM of
// ROOMS*SLOTS_PER_ROOM entries, ID_BITS wide. After reset the block sweeps the
// RAM to zero, one entry per cycle, so in_ch.ready stays low until the sweep
// ends; cfg writes are taken throughout. Each transfer on in_ch carries an
// operation (check or toggle), a room number and a card ID. The room number
// minus first_room_number selects the room; a room below the base or past the
// last room returns "invalid room". For a valid room the sequencer walks the
// room's slots, one read and one compare per slot through the RAM's single
// read port, and handles one item at a time. A check returns present or
// absent; a toggle clears the first matching slot (removed), else fills the
// first empty slot (added), else returns room full. A zero ID marks an empty
// slot, so a zero card ID matches any free slot. The result sits in an output
// register: the next item is taken while it waits on out_ch.ready.
// Write first_room_number through cfg_we/cfg_wdata only while the block is idle.
module room_access_list_toggle #(
  parameter int ROOMS          = ralt_pkg::ROOMS_DEF,
  parameter int SLOTS_PER_ROOM = ralt_pkg::SLOTS_PER_ROOM_DEF,
  parameter int ID_BITS        = ralt_pkg::ID_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ralt_in_if.sink              in_ch,
  ralt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  ralt_pkg::room_t      cfg_wdata
);
  import ralt_pkg::*;

  localparam int DEPTH = ROOMS * SLOTS_PER_ROOM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Base room register.
  room_t   first_room_r;

  // Output register, parts the sequencer from the result channel.
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r;

  res_t    res;
  logic    res_ready;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ID_BITS-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_room_r <= FIRST_ROOM_RESET;
    end else if (cfg_we) begin
      first_room_r <= cfg_wdata;
    end
  end

  // Load a new result when the register is empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the status until the transfer completes.
  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_status_r <= res.status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;

  ralt_id_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ID_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ralt_ctrl #(
    .ROOMS          (ROOMS),
    .SLOTS_PER_ROOM (SLOTS_PER_ROOM),
    .ID_BITS        (ID_BITS),
    .AW             (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .first_room (first_room_r),
    .res        (res),
    .res_ready  (res_ready),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule
